>>> src/rbrp_pkg.sv
// Shared types and constants for the base relocation directory parser.
`default_nettype none

package rbrp_pkg;

  // Entry word layout
  localparam int unsigned TYPE_SHIFT = 12;
  localparam logic [11:0] OFFSET_MASK = 12'hFFF;
  localparam logic [3:0]  TYPE_ABSOLUTE = 4'd0;
  localparam logic [3:0]  TYPE_DIR64 = 4'd10;

  // Header walk: phases 0..3 take header words, PHASE_ENTRIES takes entries
  localparam logic [2:0]  PHASE_HDR0 = 3'd0;
  localparam logic [2:0]  PHASE_ENTRIES = 3'd4;
  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [32:0] WORD_BYTES = 33'd2;
  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [0:0] CFG_RELOCATION_DELTA = 1'b0;
  localparam logic [0:0] CFG_DIRECTORY_SIZE = 1'b1;

  typedef enum logic [1:0] {
    KIND_PATCH = 2'd0,
    KIND_WARN  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [32:0] patch_rva;
    logic [3:0]  entry_type;
    logic [30:0] fixups_applied;
    logic        last_of_run;
  } result_t;

  // Results pushed into the queue for one parsed word
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Queue status back to the parser
  typedef struct packed {
    logic                room;
    logic [QUEUE_CW-1:0] count;
  } queue_status_t;

endpackage

`default_nettype wire

>>> src/rbrp_if.sv
// Request and result channel interfaces of the relocation parser.
`default_nettype none

interface rbrp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] table_word;
  logic        starts_table;

  modport source (output valid, output table_word, output starts_table, input ready);
  modport sink (input valid, input table_word, input starts_table, output ready);
endinterface

interface rbrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [32:0] patch_rva;
  logic [3:0]  entry_type;
  logic [30:0] fixups_applied;
  logic        last_of_run;

  modport source (output valid, output result_kind, output patch_rva, output entry_type,
                  output fixups_applied, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input patch_rva, input entry_type,
                input fixups_applied, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/pe_base_relocation_parser.sv
// Top level of the PE base relocation directory parser (DIR64 form).
//
// Walks a base relocation directory fed as little-endian 16-bit words, one
// request per word. Each block starts with a page offset and a block size (two
// words each, low word first); every following entry word yields a patch
// result (DIR64, page offset plus 12-bit offset), a warning result (any type
// other than DIR64 or ABSOLUTE) or nothing (ABSOLUTE padding). A finished
// result closes the walk at the directory size or at a zero block size; a
// block size below 8 or odd gives a malformed result and stops the walk. A
// request with starts_table set restarts the walk at any time; if the delta or
// the directory size is zero it gives only a finished result. The block takes
// one word per cycle while the queue has room: a word is held in the input
// register, parsed there, and its results enter a four-entry result queue
// whose head drives the result port. The result port drains one result per
// cycle while ready is high; an entry word with a result that also ends the
// directory gives two results. The input stalls only while the queue holds
// more than two results. Write configuration only while the block is idle.
`default_nettype none

module pe_base_relocation_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rbrp_in_if.sink          item_i,
  rbrp_out_if.source       result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  logic [63:0] relocation_delta_q;
  logic [31:0] directory_size_q;

  rbrp_pkg::push_t         push;
  rbrp_pkg::queue_status_t qstat;
  rbrp_pkg::result_t       out_data;

  // Configuration registers; delta only matters as zero or not at table start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relocation_delta_q <= 64'd0;
      directory_size_q   <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbrp_pkg::CFG_RELOCATION_DELTA: relocation_delta_q <= cfg_wdata_i;
        rbrp_pkg::CFG_DIRECTORY_SIZE:   directory_size_q   <= cfg_wdata_i[31:0];
        default: relocation_delta_q <= relocation_delta_q;
      endcase
    end
  end

  rbrp_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (item_i.valid),
    .in_ready_o       (item_i.ready),
    .table_word_i     (item_i.table_word),
    .starts_table_i   (item_i.starts_table),
    .delta_zero_i     (relocation_delta_q == 64'd0),
    .directory_size_i (directory_size_q),
    .qstat_i          (qstat),
    .push_o           (push)
  );

  rbrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .qstat_o     (qstat),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (out_data)
  );

  // Drive the result payload from the queue head
  assign result_o.result_kind    = out_data.result_kind;
  assign result_o.patch_rva      = out_data.patch_rva;
  assign result_o.entry_type     = out_data.entry_type;
  assign result_o.fixups_applied = out_data.fixups_applied;
  assign result_o.last_of_run    = out_data.last_of_run;

  // A second result from one word is always the closing finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.r1.result_kind == rbrp_pkg::KIND_DONE
                         && push.r1.last_of_run && !push.r0.last_of_run)
    else $error("second result of a word is not a closing finish");

  // A single result always closes its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd1 |-> push.r0.last_of_run)
    else $error("single result without last_of_run");

  // The queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= rbrp_pkg::QUEUE_CW'(rbrp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // The request side stalls only on a nearly full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> !qstat.room)
    else $error("request stalled while the queue has room");

endmodule

`default_nettype wire

>>> src/rbrp_parse.sv
// Input register and single-pass word parser with the directory walk state.
`default_nettype none

module rbrp_parse (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [15:0]            table_word_i,
  input  wire logic                   starts_table_i,
  input  wire logic                   delta_zero_i,
  input  wire logic [31:0]            directory_size_i,
  input  wire rbrp_pkg::queue_status_t qstat_i,
  output rbrp_pkg::push_t             push_o
);

  // Input register
  logic        in_vq;
  logic [15:0] word_q;
  logic        start_q;
  logic        advance;

  // Walk state
  logic [2:0]  phase_q, phase_d;
  logic [31:0] bpo_q, bpo_d;
  logic [31:0] blen_q, blen_d;
  logic [30:0] eleft_q, eleft_d;
  logic [32:0] bytes_q, bytes_d;
  logic [30:0] pcount_q, pcount_d;
  logic        done_q, done_d;

  // Values after an optional restart
  logic [2:0]  phase_c;
  logic [31:0] bpo_c;
  logic [31:0] blen_c;
  logic [30:0] eleft_c;
  logic [32:0] bytes_c;
  logic [30:0] pcount_c;
  logic        done_c;

  logic [32:0] bytes_n;
  logic [31:0] blen_new;
  logic [31:0] blen_sub;
  logic [30:0] eleft_n;
  logic [3:0]  etype;
  logic [11:0] eoffs;
  logic        end_hit;
  logic [1:0]  n;
  rbrp_pkg::result_t r0, r1;

  assign advance    = in_vq && qstat_i.room;
  assign in_ready_o = !in_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q  <= table_word_i;
      start_q <= starts_table_i;
    end
  end

  assign phase_c  = start_q ? rbrp_pkg::PHASE_HDR0 : phase_q;
  assign bpo_c    = start_q ? 32'd0 : bpo_q;
  assign blen_c   = start_q ? 32'd0 : blen_q;
  assign eleft_c  = start_q ? 31'd0 : eleft_q;
  assign bytes_c  = start_q ? 33'd0 : bytes_q;
  assign pcount_c = start_q ? 31'd0 : pcount_q;
  assign done_c   = start_q ? 1'b0 : done_q;

  assign bytes_n  = bytes_c + rbrp_pkg::WORD_BYTES;
  assign blen_new = {word_q, blen_c[15:0]};
  assign blen_sub = blen_new - rbrp_pkg::HDR_BYTES;
  assign etype    = word_q[15:rbrp_pkg::TYPE_SHIFT];
  assign eoffs    = word_q[11:0] & rbrp_pkg::OFFSET_MASK;
  assign eleft_n  = (eleft_c != 31'd0) ? eleft_c - 31'd1 : eleft_c;
  assign end_hit  = bytes_n >= {1'b0, directory_size_i};

  always_comb begin
    phase_d  = phase_c;
    bpo_d    = bpo_c;
    blen_d   = blen_c;
    eleft_d  = eleft_c;
    bytes_d  = bytes_c;
    pcount_d = pcount_c;
    done_d   = done_c;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;

    if (start_q && (directory_size_i == 32'd0 || delta_zero_i)) begin
      // Nothing to relocate: report an empty finish and stay idle
      r0.result_kind = rbrp_pkg::KIND_DONE;
      done_d         = 1'b1;
      n              = 2'd1;
    end else if (!done_c) begin
      bytes_d = bytes_n;
      if (phase_c != rbrp_pkg::PHASE_ENTRIES) begin
        phase_d = phase_c + 3'd1;
        case (phase_c[1:0])
          2'd0: bpo_d = {16'd0, word_q};
          2'd1: bpo_d = {word_q, bpo_c[15:0]};
          2'd2: blen_d = {16'd0, word_q};
          2'd3: begin
            blen_d = blen_new;
            if (blen_new == 32'd0) begin
              r0.result_kind    = rbrp_pkg::KIND_DONE;
              r0.fixups_applied = pcount_c;
              done_d            = 1'b1;
              n                 = 2'd1;
            end else if (blen_new < rbrp_pkg::HDR_BYTES || blen_new[0]) begin
              r0.result_kind    = rbrp_pkg::KIND_BAD;
              r0.fixups_applied = pcount_c;
              done_d            = 1'b1;
              n                 = 2'd1;
            end else begin
              eleft_d = blen_sub[31:1];
              if (blen_sub[31:1] == 31'd0) begin
                // Header-only block: check the directory end right away
                phase_d = rbrp_pkg::PHASE_HDR0;
                if (end_hit) begin
                  r0.result_kind    = rbrp_pkg::KIND_DONE;
                  r0.fixups_applied = pcount_c;
                  done_d            = 1'b1;
                  n                 = 2'd1;
                end
              end
            end
          end
          default: bpo_d = bpo_c;
        endcase
      end else begin
        if (etype == rbrp_pkg::TYPE_DIR64) begin
          pcount_d          = (pcount_c < rbrp_pkg::COUNT_MAX) ? pcount_c + 31'd1 : pcount_c;
          r0.result_kind    = rbrp_pkg::KIND_PATCH;
          r0.patch_rva      = {1'b0, bpo_c} + {21'd0, eoffs};
          r0.entry_type     = etype;
          r0.fixups_applied = pcount_d;
          n                 = 2'd1;
        end else if (etype != rbrp_pkg::TYPE_ABSOLUTE) begin
          r0.result_kind    = rbrp_pkg::KIND_WARN;
          r0.entry_type     = etype;
          r0.fixups_applied = pcount_c;
          n                 = 2'd1;
        end
        eleft_d = eleft_n;
        if (eleft_n == 31'd0) begin
          phase_d = rbrp_pkg::PHASE_HDR0;
          if (end_hit) begin
            done_d = 1'b1;
            if (n == 2'd0) begin
              r0.result_kind    = rbrp_pkg::KIND_DONE;
              r0.fixups_applied = pcount_d;
              n                 = 2'd1;
            end else begin
              r1.result_kind    = rbrp_pkg::KIND_DONE;
              r1.fixups_applied = pcount_d;
              n                 = 2'd2;
            end
          end
        end
      end
    end

    // Mark the final result of this word
    if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rbrp_pkg::PHASE_HDR0;
      bpo_q    <= 32'd0;
      blen_q   <= 32'd0;
      eleft_q  <= 31'd0;
      bytes_q  <= 33'd0;
      pcount_q <= 31'd0;
      done_q   <= 1'b1;
    end else if (advance) begin
      phase_q  <= phase_d;
      bpo_q    <= bpo_d;
      blen_q   <= blen_d;
      eleft_q  <= eleft_d;
      bytes_q  <= bytes_d;
      pcount_q <= pcount_d;
      done_q   <= done_d;
    end
  end

  assign push_o.cnt = advance ? n : 2'd0;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

endmodule

`default_nettype wire

>>> src/rbrp_queue.sv
// Result queue: takes up to two results per cycle, hands out one if ready.
`default_nettype none

module rbrp_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rbrp_pkg::push_t        push_i,
  output rbrp_pkg::queue_status_t     qstat_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output rbrp_pkg::result_t           out_data_o
);

  rbrp_pkg::result_t mem_q [rbrp_pkg::QUEUE_DEPTH];
  logic [rbrp_pkg::QUEUE_AW-1:0] wr_q, rd_q;
  logic [rbrp_pkg::QUEUE_AW-1:0] wr_1;
  logic [rbrp_pkg::QUEUE_CW-1:0] count_q, count_d;
  logic pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];
  assign wr_1        = wr_q + rbrp_pkg::QUEUE_AW'(1);

  // Room for a word that may cause two results
  assign qstat_o.room  = count_q <= rbrp_pkg::QUEUE_CW'(rbrp_pkg::QUEUE_DEPTH - 2);
  assign qstat_o.count = count_q;

  assign count_d = count_q + rbrp_pkg::QUEUE_CW'(push_i.cnt)
                 - rbrp_pkg::QUEUE_CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + rbrp_pkg::QUEUE_AW'(push_i.cnt);
      rd_q    <= rd_q + rbrp_pkg::QUEUE_AW'(pop);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_1] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire
